FILE: rtl/bnsqrt_pkg.sv
// Shared types, constants and helper functions for the bisection/Newton square root block.
// No dependencies; every other file in rtl/ imports this package.
`default_nettype none

package bnsqrt_pkg;

  localparam int unsigned OPERAND_W  = 32;
  localparam int unsigned ROOT_W     = 24;
  localparam int unsigned DIVISOR_W  = 64;
  localparam int unsigned BRACKET_W  = 32;

  localparam int unsigned DEF_BISECT_STEPS = 11;
  localparam int unsigned DEF_NEWTON_STEPS = 16;
  localparam int unsigned DEF_FRAC_BITS    = 16;

  localparam logic [ROOT_W-1:0] ROOT_MAX    = '1;
  localparam logic [7:0]        RATIO_NUM   = 8'd210;
  localparam int unsigned       RATIO_SHIFT = 8;
  localparam int unsigned       RATIO_W     = BRACKET_W + RATIO_SHIFT;

  // floor((r + q) / 2) without overflow
  function automatic logic [DIVISOR_W-1:0] newton_image(input logic [DIVISOR_W-1:0] r,
                                                        input logic [DIVISOR_W-1:0] q);
    return (r >> 1) + (q >> 1) + {{(DIVISOR_W-1){1'b0}}, r[0] & q[0]};
  endfunction

  function automatic logic [ROOT_W-1:0] sat_root(input logic [DIVISOR_W-1:0] v);
    return (v > DIVISOR_W'(ROOT_MAX)) ? ROOT_MAX : v[ROOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bnsqrt_in_if.sv
// Operand channel: valid/ready handshake carrying one unsigned fixed-point operand.
// Depends on bnsqrt_pkg for the field width.
`default_nettype none

interface bnsqrt_in_if
  import bnsqrt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [OPERAND_W-1:0] operand;

  modport source (output valid, output operand, input ready);
  modport sink   (input valid, input operand, output ready);
endinterface

`default_nettype wire

FILE: rtl/bnsqrt_out_if.sv
// Result channel: valid/ready handshake carrying the root and the exact-hit flag.
// Depends on bnsqrt_pkg for the field width.
`default_nettype none

interface bnsqrt_out_if
  import bnsqrt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;
  logic              found_by_bisection;

  modport source (output valid, output root, output found_by_bisection, input ready);
  modport sink   (input valid, input root, input found_by_bisection, output ready);
endinterface

`default_nettype wire

FILE: rtl/bnsqrt_div.sv
// Serial restoring divider, one quotient bit per cycle, shared by every phase of the root search.
// Depends on bnsqrt_pkg for the divisor width.
`default_nettype none

module bnsqrt_div
  import bnsqrt_pkg::*;
#(
  parameter int unsigned DIVIDEND_W = OPERAND_W + DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [DIVISOR_W-1:0]  remainder
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  assign trial = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = ~diff[DIVISOR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

FILE: rtl/bisect_newton_square_root_top.sv
// Square root of an unsigned fixed-point operand by bisection followed by Newton refinement.
// An operand of zero or one returns at once: accept, then the result is valid in the next cycle.
// Any other operand runs on one shared serial divider that delivers one quotient bit a cycle.
// A bisection step takes one division for the midpoint square test and, when the interval ratio
// is met, up to two more for the Newton images of its ends; the Newton phase takes one division
// per step unless its estimate is zero. Worst case is about (3 * BISECT_STEPS + NEWTON_STEPS)
// divisions. The block takes one operand at a time and holds ready low until its result leaves.
// Depends on bnsqrt_pkg, bnsqrt_in_if, bnsqrt_out_if and bnsqrt_div.
`default_nettype none

module bisect_newton_square_root_top
  import bnsqrt_pkg::*;
#(
  parameter int unsigned BISECT_STEPS = DEF_BISECT_STEPS,
  parameter int unsigned NEWTON_STEPS = DEF_NEWTON_STEPS,
  parameter int unsigned FRAC_BITS    = DEF_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  bnsqrt_in_if.sink    in_ch,
  bnsqrt_out_if.source out_ch
);

  localparam int unsigned DIVIDEND_W = OPERAND_W + FRAC_BITS;
  localparam int unsigned BS_W       = $clog2(BISECT_STEPS + 1);
  localparam int unsigned NS_W       = $clog2(NEWTON_STEPS + 1);
  localparam logic [OPERAND_W-1:0] ONE = OPERAND_W'(1) << FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_GA, S_GB, S_SQ, S_NSTEP, S_NWAIT, S_OUT
  } state_t;

  state_t                 state_r;
  logic [OPERAND_W-1:0]   x_r;
  logic [BRACKET_W-1:0]   a_r;
  logic [BRACKET_W-1:0]   b_r;
  logic [BRACKET_W-1:0]   mid_r;
  logic [DIVISOR_W-1:0]   r_r;
  logic [BS_W-1:0]        steps_r;
  logic [NS_W-1:0]        n_r;
  logic [ROOT_W-1:0]      root_r;
  logic                   found_r;
  logic                   out_valid_r;
  logic                   div_start_r;
  logic [DIVISOR_W-1:0]   div_divisor_r;

  logic                   div_done;
  logic [DIVIDEND_W-1:0]  div_quo;
  logic [DIVISOR_W-1:0]   div_rem;
  logic [DIVIDEND_W-1:0]  target;

  logic [BRACKET_W:0]     sum_ab;
  logic [BRACKET_W-1:0]   mid;
  logic [RATIO_W-1:0]     ratio_lo;
  logic [RATIO_W-1:0]     ratio_hi;
  logic                   ratio_ok;
  logic [DIVISOR_W-1:0]   q64;
  logic [DIVISOR_W-1:0]   mid64;
  logic [DIVISOR_W-1:0]   g_in;
  logic [DIVISOR_W-1:0]   g_val;
  logic [DIVISOR_W-1:0]   g_inf;
  logic                   sq_hit;
  logic                   sq_lt;

  assign target = {x_r, {FRAC_BITS{1'b0}}};

  bnsqrt_div #(
    .DIVIDEND_W (DIVIDEND_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend  (target),
    .divisor   (div_divisor_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign sum_ab   = {1'b0, a_r} + {1'b0, b_r};
  assign mid      = sum_ab[BRACKET_W:1];
  assign ratio_lo = {a_r, {RATIO_SHIFT{1'b0}}};
  assign ratio_hi = RATIO_W'(RATIO_NUM) * RATIO_W'(b_r);
  assign ratio_ok = ratio_lo >= ratio_hi;

  assign q64   = DIVISOR_W'(div_quo);
  assign mid64 = DIVISOR_W'(mid_r);

  always_comb begin
    case (state_r)
      S_GA:    g_in = DIVISOR_W'(a_r);
      S_GB:    g_in = DIVISOR_W'(b_r);
      default: g_in = r_r;
    endcase
  end

  assign g_val = newton_image(g_in, q64);
  assign g_inf = newton_image('0, '1);

  // mid * mid against target, read from target = q * mid + rem
  assign sq_hit = (q64 == mid64) && (div_rem == '0);
  assign sq_lt  = (mid64 < q64) || ((q64 == mid64) && (div_rem != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_r <= in_ch.operand;
            if (in_ch.operand == '0 || in_ch.operand == ONE) begin
              root_r      <= sat_root(DIVISOR_W'(in_ch.operand));
              found_r     <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              a_r     <= '0;
              b_r     <= (in_ch.operand > ONE) ? in_ch.operand : ONE;
              steps_r <= '0;
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (steps_r == BS_W'(BISECT_STEPS)) begin
            r_r     <= DIVISOR_W'(mid);
            n_r     <= '0;
            state_r <= S_NSTEP;
          end else if (!ratio_ok) begin
            mid_r         <= mid;
            div_start_r   <= 1'b1;
            div_divisor_r <= DIVISOR_W'(mid);
            state_r       <= S_SQ;
          end else begin
            div_start_r   <= 1'b1;
            div_divisor_r <= DIVISOR_W'(a_r);
            state_r       <= S_GA;
          end
        end
        S_GA: begin
          if (div_done) begin
            if (g_val > DIVISOR_W'(b_r)) begin
              mid_r         <= mid;
              div_start_r   <= 1'b1;
              div_divisor_r <= DIVISOR_W'(mid);
              state_r       <= S_SQ;
            end else begin
              div_start_r   <= 1'b1;
              div_divisor_r <= DIVISOR_W'(b_r);
              state_r       <= S_GB;
            end
          end
        end
        S_GB: begin
          if (div_done) begin
            if (g_val <= DIVISOR_W'(b_r)) begin
              r_r     <= DIVISOR_W'(mid);
              n_r     <= '0;
              state_r <= S_NSTEP;
            end else begin
              mid_r         <= mid;
              div_start_r   <= 1'b1;
              div_divisor_r <= DIVISOR_W'(mid);
              state_r       <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (div_done) begin
            if (sq_hit) begin
              root_r      <= sat_root(mid64);
              found_r     <= 1'b1;
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              if (sq_lt) begin
                a_r <= mid_r;
              end else begin
                b_r <= mid_r;
              end
              steps_r <= steps_r + BS_W'(1);
              state_r <= S_CHECK;
            end
          end
        end
        S_NSTEP: begin
          if (n_r == NS_W'(NEWTON_STEPS)) begin
            root_r      <= sat_root(r_r);
            found_r     <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_OUT;
          end else if (r_r == '0) begin
            r_r <= g_inf;
            n_r <= n_r + NS_W'(1);
          end else begin
            div_start_r   <= 1'b1;
            div_divisor_r <= r_r;
            state_r       <= S_NWAIT;
          end
        end
        S_NWAIT: begin
          if (div_done) begin
            r_r     <= g_val;
            n_r     <= n_r + NS_W'(1);
            state_r <= S_NSTEP;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.root               = root_r;
  assign out_ch.found_by_bisection = found_r;

endmodule

`default_nettype wire
